// File: rtl/vrq_pkg.sv
// Shared types and constants for the vruntime run queue scheduler.
`default_nettype none
package vrq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int TASK_ID_BITS = 8;
  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int PTR_W = IDX_W + 1;
  localparam int RT_W = 63;
  localparam int PR_W = 4;
  localparam int SLICE_W = 12;
  localparam int BASE_W = 8;
  localparam int RUN_W = 7;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 64;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_SLICE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_ID = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_RT = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_PR = 8'd3;

  // item function codes
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_SCHED = 1'b1;

  typedef struct packed {
    logic [TASK_ID_BITS-1:0] id;
    logic [RT_W-1:0] rt;
    logic [PR_W-1:0] pr;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROUTE,
    ST_POP_RD,
    ST_POP_TAKE,
    ST_DECIDE,
    ST_INS_CHK,
    ST_INS_RD,
    ST_INS_CMP,
    ST_AFTER_INS,
    ST_SLICE,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic rd_head;
    logic pop_take;
    logic take_idle;
    logic decide;
    logic ins_chk;
    logic shift;
    logic place;
    logic div_start;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic func;
    logic len_zero;
    logic ins_needed;
    logic ins_skip;
    logic p_zero;
    logic cmp_ge;
    logic slice_zero;
    logic div_last;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// File: rtl/vrq_ctrl.sv
// Controller state machine sequencing pop, sorted insert and slice divide.
`default_nettype none
module vrq_ctrl import vrq_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  input  wire status_t sts,
  output cmd_t         cmd,
  output logic         busy
);

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    busy = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = ST_ROUTE;
        end
      end
      ST_ROUTE: begin
        state_next = (sts.func == FUNC_SCHED) ? ST_POP_RD : ST_INS_CHK;
      end
      ST_POP_RD: begin
        cmd.rd_head = 1'b1;
        state_next = ST_POP_TAKE;
      end
      ST_POP_TAKE: begin
        if (sts.len_zero) cmd.take_idle = 1'b1;
        else cmd.pop_take = 1'b1;
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = sts.ins_needed ? ST_INS_CHK : ST_SLICE;
      end
      ST_INS_CHK: begin
        cmd.ins_chk = 1'b1;
        state_next = sts.ins_skip ? ST_AFTER_INS : ST_INS_RD;
      end
      ST_INS_RD: begin
        if (sts.p_zero) begin
          cmd.place = 1'b1;
          state_next = ST_AFTER_INS;
        end else begin
          state_next = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        if (sts.cmp_ge) begin
          cmd.shift = 1'b1;
          state_next = ST_INS_RD;
        end else begin
          cmd.place = 1'b1;
          state_next = ST_AFTER_INS;
        end
      end
      ST_AFTER_INS: begin
        state_next = (sts.func == FUNC_SCHED) ? ST_SLICE : ST_DONE;
      end
      ST_SLICE: begin
        cmd.div_start = 1'b1;
        state_next = sts.slice_zero ? ST_DIV : ST_DONE;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/vrq_datapath.sv
// Datapath: config registers, circular sorted queue memory, divider, result word.
`default_nettype none
module vrq_datapath import vrq_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire cmd_t                    cmd,
  output status_t                      sts,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                    func,
  input  wire logic [TASK_ID_BITS-1:0] task_id,
  input  wire logic [RT_W-1:0]         task_vruntime,
  input  wire logic [PR_W-1:0]         task_priority,
  input  wire logic                    still_running,
  input  wire logic [SLICE_W-1:0]      slice_left,
  input  wire logic                    out_stall,
  output logic                         out_valid,
  output logic                         do_switch,
  output logic [TASK_ID_BITS-1:0]      next_task_id,
  output logic [SLICE_W-1:0]           slice_out,
  output logic [RUN_W-1:0]             runnable_count,
  output logic                         queue_full
);

  // configuration
  logic [BASE_W-1:0] base_slice;
  logic [TASK_ID_BITS-1:0] idle_id;
  logic [RT_W-1:0] idle_rt;
  logic [PR_W-1:0] idle_pr;

  // latched item
  logic it_func, it_run;
  entry_t it;
  logic [SLICE_W-1:0] it_slice;

  // popped task, insert operand, result fields
  entry_t popped, ins;
  logic sw_flag, full_flag;
  logic [TASK_ID_BITS-1:0] nid;

  // queue bookkeeping
  logic [IDX_W-1:0] head;
  logic [PTR_W-1:0] len, p;
  entry_t mem [QUEUE_DEPTH];
  entry_t rd_data;

  // divider
  logic [BASE_W-1:0] quot;
  logic [BASE_W-1:0] rem;
  logic [$clog2(BASE_W)-1:0] div_cnt;

  logic sw;
  logic ins_idle, ins_full;
  logic [PTR_W-1:0] rd_log, wr_log;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic [RUN_W-1:0] count;
  logic [BASE_W-1:0] rem_sh;
  logic div_ge;
  logic [SLICE_W-1:0] prod, slice_val;

  // logical position to physical address around the head
  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] h,
                                            input logic [PTR_W-1:0] l);
    logic [PTR_W:0] s;
    s = {2'b00, h} + {1'b0, l};
    if (s >= (PTR_W+1)'(QUEUE_DEPTH)) s = s - (PTR_W+1)'(QUEUE_DEPTH);
    return s[IDX_W-1:0];
  endfunction

  assign rd_log = cmd.rd_head ? '0 : p - PTR_W'(1);
  assign wr_log = p;
  assign rd_addr = phys(head, rd_log);
  assign wr_addr = phys(head, wr_log);

  assign sw = (it.rt >= popped.rt) || !it_run;
  assign ins_idle = (ins.id == idle_id);
  assign ins_full = (len >= PTR_W'(QUEUE_DEPTH));
  assign count = RUN_W'(len) + RUN_W'(1);

  assign rem_sh = {rem[BASE_W-2:0], quot[BASE_W-1]};
  assign div_ge = (rem_sh >= BASE_W'(count));

  assign prod = SLICE_W'(quot) * SLICE_W'(it.pr);

  // slice for the result word
  always_comb begin
    if (it_func == FUNC_INSERT) slice_val = '0;
    else if (it_slice != '0) slice_val = it_slice;
    else if (popped.pr <= PR_W'(1)) slice_val = SLICE_W'(quot);
    else slice_val = prod;
  end

  // status to the controller
  always_comb begin
    sts.func = it_func;
    sts.len_zero = (len == '0);
    sts.ins_needed = !sw || it_run;
    sts.ins_skip = ins_idle || ins_full;
    sts.p_zero = (p == '0);
    sts.cmp_ge = (rd_data.rt >= ins.rt);
    sts.slice_zero = (it_slice == '0);
    sts.div_last = (div_cnt == '1);
    sts.out_free = !out_valid || !out_stall;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_slice <= BASE_W'(4);
      idle_id <= '0;
      idle_rt <= '0;
      idle_pr <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BASE_SLICE: base_slice <= cfg_data[BASE_W-1:0];
        CFG_IDLE_ID: idle_id <= cfg_data[TASK_ID_BITS-1:0];
        CFG_IDLE_RT: idle_rt <= cfg_data[RT_W-1:0];
        CFG_IDLE_PR: idle_pr <= cfg_data[PR_W-1:0];
        default: ;
      endcase
    end
  end

  // queue memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.shift) mem[wr_addr] <= rd_data;
    else if (cmd.place) mem[wr_addr] <= ins;
    rd_data <= mem[rd_addr];
  end

  // queue control state
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      len <= '0;
    end else begin
      if (cmd.pop_take) begin
        head <= (head == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head + IDX_W'(1);
        len <= len - PTR_W'(1);
      end else if (cmd.place) begin
        len <= len + PTR_W'(1);
      end
    end
  end

  // item, decision and insert operands
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it_func <= func;
      it.id <= task_id;
      it.rt <= task_vruntime;
      it.pr <= task_priority;
      it_run <= still_running;
      it_slice <= slice_left;
      sw_flag <= 1'b0;
      full_flag <= 1'b0;
      nid <= '0;
      ins.id <= task_id;
      ins.rt <= task_vruntime;
      ins.pr <= task_priority;
    end
    if (cmd.take_idle) begin
      popped.id <= idle_id;
      popped.rt <= idle_rt;
      popped.pr <= idle_pr;
    end else if (cmd.pop_take) begin
      popped <= rd_data;
    end
    if (cmd.decide) begin
      if (sw) begin
        sw_flag <= 1'b1;
        nid <= popped.id;
        ins <= it;
      end else begin
        nid <= it.id;
        ins <= popped;
      end
    end
    if (cmd.ins_chk) begin
      full_flag <= !ins_idle && ins_full;
      p <= len;
    end else if (cmd.shift) begin
      p <= p - PTR_W'(1);
    end
  end

  // restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quot <= base_slice;
      rem <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      quot <= {quot[BASE_W-2:0], div_ge};
      rem <= div_ge ? rem_sh - BASE_W'(count) : rem_sh;
      div_cnt <= div_cnt + ($clog2(BASE_W))'(1);
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      do_switch <= sw_flag;
      next_task_id <= nid;
      slice_out <= slice_val;
      runnable_count <= count;
      queue_full <= full_flag;
    end
  end

endmodule
`default_nettype wire

// File: rtl/vruntime_run_queue_scheduler.sv
// Top level of the vruntime run queue scheduler.
// A run queue of up to 64 tasks kept in ascending virtual runtime, stored as a
// circular buffer in one single-port-write, registered-read memory. One word is
// handled at a time; in_stall is high from acceptance until the result word is
// loaded into the output register, which then waits independently for out_stall.
// An insert that is dropped or carries the idle id skips the queue; any other
// insert moves each queued entry whose runtime is not below the new one up one
// place, one entry at a time through the memory port, and then writes the new
// entry into the place so freed, at the head or elsewhere. A schedule pops the
// head or takes the idle task, and may requeue one task in the same way; when
// slice_left is zero the bit-serial slice divider then runs. The block accepts
// the next word in the cycle after the result word is loaded.
// Configuration (index 0 base_slice, 1 idle_task_id, 2 idle_vruntime,
// 3 idle_priority) is always ready and should be written only while idle.
`default_nettype none
module vruntime_run_queue_scheduler import vrq_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic                    func,
  input  wire logic [TASK_ID_BITS-1:0] task_id,
  input  wire logic [RT_W-1:0]         task_vruntime,
  input  wire logic [PR_W-1:0]         task_priority,
  input  wire logic                    still_running,
  input  wire logic [SLICE_W-1:0]      slice_left,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic                         do_switch,
  output logic [TASK_ID_BITS-1:0]      next_task_id,
  output logic [SLICE_W-1:0]           slice_out,
  output logic [RUN_W-1:0]             runnable_count,
  output logic                         queue_full
);

  cmd_t cmd;
  status_t sts;
  logic busy;

  assign cfg_ready = 1'b1;
  assign in_stall = busy;

  vrq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy)
  );

  vrq_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_valid & cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .func           (func),
    .task_id        (task_id),
    .task_vruntime  (task_vruntime),
    .task_priority  (task_priority),
    .still_running  (still_running),
    .slice_left     (slice_left),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .do_switch      (do_switch),
    .next_task_id   (next_task_id),
    .slice_out      (slice_out),
    .runnable_count (runnable_count),
    .queue_full     (queue_full)
  );

endmodule
`default_nettype wire

// File: rtl/vrq_checker.sv
// Port-level checker for the run queue scheduler, bound to the top level.
`default_nettype none
module vrq_checker import vrq_pkg::*; (
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    in_valid,
  input wire logic                    in_stall,
  input wire logic                    out_valid,
  input wire logic                    out_stall,
  input wire logic                    do_switch,
  input wire logic [TASK_ID_BITS-1:0] next_task_id,
  input wire logic [SLICE_W-1:0]      slice_out,
  input wire logic [RUN_W-1:0]        runnable_count,
  input wire logic                    queue_full
);

  // an accepted word keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted but block not busy next cycle");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(next_task_id) && $stable(slice_out))
    else $error("stalled result word changed");

  // a dropped insert never orders a switch
  a_full_no_switch: assert property (@(posedge clk) disable iff (rst)
    out_valid && queue_full |-> !do_switch && next_task_id == '0 && slice_out == '0)
    else $error("dropped insert carries schedule fields");

  // the idle task is always counted
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> runnable_count != '0)
    else $error("runnable count is zero");

endmodule

bind vruntime_run_queue_scheduler vrq_checker u_vrq_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .do_switch      (do_switch),
  .next_task_id   (next_task_id),
  .slice_out      (slice_out),
  .runnable_count (runnable_count),
  .queue_full     (queue_full)
);
`default_nettype wire
